/* rtl/core/lpht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared request and response types, request and status codes, and the
// fixed table geometry.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int TABLE_SLOTS   = 256;
   localparam int SLOT_BITS     = 8;
   localparam int COUNT_BITS    = 9;
   localparam int REQ_KEY_BITS  = 32;
   localparam int REQ_VAL_BITS  = 32;
   localparam int HASH_BITS     = 8;
   localparam int STATUS_BITS   = 3;

   localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(TABLE_SLOTS);

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_FOUND    = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_MISSING  = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NEW      = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_REPLACED = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 3'd4;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [REQ_KEY_BITS-1:0] key;
      logic [HASH_BITS-1:0]    hash_value;
      logic [REQ_VAL_BITS-1:0] value;
   } lpht_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [REQ_VAL_BITS-1:0] read_value;
      logic [COUNT_BITS-1:0]   entry_count;
   } lpht_rsp_type;

   typedef struct packed {
      logic                 key_we;
      logic                 value_we;
      logic [SLOT_BITS-1:0] addr;
   } lpht_ent_wr_type;

endpackage

/* rtl/core/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressed key/value table with a slot memory that maps probe positions
// to densely stored entries, and a sequencer that walks slots linearly.
//
//   Channel   Ports                     Handshake
//   request   start, busy, req_data     taken when start is high, busy low
//   response  rsp_valid, rsp_data       one-cycle strobe, cannot be stalled
//
// A clear or an unused request answers in the cycle after it is taken.
// A lookup or insert examines each occupied slot in three steps (slot read,
// entry read, key compare) and stops at a matching key, at an empty slot, or
// after every slot of a full table has been examined.
// Reset empties all slots at once through per-slot valid flops.
// The response strobe rises at the edge where busy falls, so the next request
// can be taken in the cycle the response is shown.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  lpht_req_type req_data,
   output logic         busy,
   output logic         rsp_valid,
   output lpht_rsp_type rsp_data
);

   localparam int KW = (KEY_BITS < REQ_KEY_BITS) ? KEY_BITS : REQ_KEY_BITS;
   localparam int VW = (VALUE_BITS < REQ_VAL_BITS) ? VALUE_BITS : REQ_VAL_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SLOT,
      S_ENTRY,
      S_COMPARE
   } state_type;

   state_type               state_ff;
   logic [1:0]              op_ff;
   logic [KW-1:0]           key_ff;
   logic [VW-1:0]           value_ff;
   logic [SLOT_BITS-1:0]    pos_ff;
   logic [SLOT_BITS-1:0]    steps_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [TABLE_SLOTS-1:0]  valid_ff;
   logic                    rsp_valid_ff;
   lpht_rsp_type            rsp_ff;

   logic [SLOT_BITS-1:0]    slot_mem [TABLE_SLOTS];
   logic [SLOT_BITS-1:0]    slot_rd_ff;

   logic                    accept;
   logic                    slot_empty;
   logic                    room;
   logic                    new_insert;
   logic                    key_hit;
   logic                    replace;
   logic [COUNT_BITS-1:0]   count_in;
   lpht_ent_wr_type         ent_wr;
   logic [KW-1:0]           rd_key;
   logic [VW-1:0]           rd_value;

   assign accept     = start && !busy;
   assign slot_empty = !valid_ff[pos_ff];
   assign room       = !count_ff[COUNT_BITS-1];
   assign new_insert = (state_ff == S_SLOT) && slot_empty && (op_ff == REQ_INSERT) && room;
   assign key_hit    = (rd_key == key_ff);
   assign replace    = (state_ff == S_COMPARE) && key_hit && (op_ff == REQ_INSERT);
   assign count_in   = count_ff + COUNT_BITS'(1);

   always_comb begin
      ent_wr.key_we   = new_insert;
      ent_wr.value_we = new_insert || replace;
      ent_wr.addr     = new_insert ? count_ff[SLOT_BITS-1:0] : slot_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (new_insert) begin
         slot_mem[pos_ff] <= count_ff[SLOT_BITS-1:0];
      end
      slot_rd_ff <= slot_mem[pos_ff];
   end

   lpht_entry_mem #(
      .KW (KW),
      .VW (VW)
   ) u_entry_mem (
      .clock    (clock),
      .wr       (ent_wr),
      .wr_key   (key_ff),
      .wr_value (value_ff),
      .rd_addr  (slot_rd_ff),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_data.req_type;
                  key_ff   <= req_data.key[KW-1:0];
                  value_ff <= req_data.value[VW-1:0];
                  pos_ff   <= req_data.hash_value[SLOT_BITS-1:0];
                  steps_ff <= '0;
                  case (req_data.req_type)
                     REQ_LOOKUP, REQ_INSERT: begin
                        state_ff <= S_SLOT;
                     end
                     REQ_CLEAR: begin
                        valid_ff            <= '0;
                        count_ff            <= '0;
                        rsp_valid_ff        <= 1'b1;
                        rsp_ff.status       <= STATUS_FOUND;
                        rsp_ff.read_value   <= '0;
                        rsp_ff.entry_count  <= '0;
                     end
                     default: begin
                        rsp_valid_ff        <= 1'b1;
                        rsp_ff.status       <= STATUS_MISSING;
                        rsp_ff.read_value   <= '0;
                        rsp_ff.entry_count  <= count_ff;
                     end
                  endcase
               end
            end
            S_SLOT: begin
               if (slot_empty) begin
                  state_ff           <= S_IDLE;
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.read_value  <= '0;
                  rsp_ff.entry_count <= count_ff;
                  if (new_insert) begin
                     valid_ff[pos_ff]   <= 1'b1;
                     count_ff           <= count_in;
                     rsp_ff.status      <= STATUS_NEW;
                     rsp_ff.entry_count <= count_in;
                  end else if (op_ff == REQ_INSERT) begin
                     rsp_ff.status <= STATUS_FULL;
                  end else begin
                     rsp_ff.status <= STATUS_MISSING;
                  end
               end else begin
                  state_ff <= S_ENTRY;
               end
            end
            S_ENTRY: begin
               state_ff <= S_COMPARE;
            end
            S_COMPARE: begin
               if (key_hit) begin
                  state_ff           <= S_IDLE;
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.entry_count <= count_ff;
                  if (op_ff == REQ_INSERT) begin
                     rsp_ff.status     <= STATUS_REPLACED;
                     rsp_ff.read_value <= '0;
                  end else begin
                     rsp_ff.status     <= STATUS_FOUND;
                     rsp_ff.read_value <= REQ_VAL_BITS'(rd_value);
                  end
               end else if (steps_ff == '1) begin
                  state_ff           <= S_IDLE;
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.status      <= STATUS_FULL;
                  rsp_ff.read_value  <= '0;
                  rsp_ff.entry_count <= count_ff;
               end else begin
                  pos_ff   <= pos_ff + SLOT_BITS'(1);
                  steps_ff <= steps_ff + SLOT_BITS'(1);
                  state_ff <= S_SLOT;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Response strobe raised while a request is in progress.");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("Entry count exceeds the slot count.");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.req_type == REQ_CLEAR)
      |=> rsp_valid && (rsp_data.entry_count == '0) && (valid_ff == '0))
      else $error("Clear request did not empty the table.");

   a_new_counts : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_NEW)
      |-> (rsp_data.entry_count == count_ff) && (count_ff != '0))
      else $error("New insert response disagrees with the entry count.");

endmodule

/* rtl/core/lpht_entry_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table entry storage
// Key and value memories indexed by entry number, one write port and one
// read port, read data registered.
// ----------------------------------------------------------------------------
module lpht_entry_mem
   import lpht_pkg::*;
#(
   parameter int KW = 32,
   parameter int VW = 32
) (
   input  logic                 clock,
   input  lpht_ent_wr_type      wr,
   input  logic [KW-1:0]        wr_key,
   input  logic [VW-1:0]        wr_value,
   input  logic [SLOT_BITS-1:0] rd_addr,
   output logic [KW-1:0]        rd_key,
   output logic [VW-1:0]        rd_value
);

   logic [KW-1:0] key_mem   [TABLE_SLOTS];
   logic [VW-1:0] value_mem [TABLE_SLOTS];
   logic [KW-1:0] rd_key_ff;
   logic [VW-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem[wr.addr] <= wr_key;
      end
      if (wr.value_we) begin
         value_mem[wr.addr] <= wr_value;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives lookup, insert, clear and unused requests through the start/busy
// port and checks every response strobe against a scoreboard model of the
// slot table and entry stores, or against a directed row's fixed response. A
// short table of directed requests comes first. Three pacing phases follow,
// each with a random mix over a small key pool and a table fill to capacity.
// ----------------------------------------------------------------------------
module testbench;
   import lpht_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int DIRECTED_ROWS = 19;
   localparam int POOL_KEYS = 32;
   localparam int MIXED_REQUESTS = 330;

   typedef enum int {PROBE_MATCH, PROBE_EMPTY, PROBE_EXHAUSTED} probe_outcome_type;

   typedef struct {
      lpht_req_type req;
      bit           fixed;
      lpht_rsp_type rsp;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         start;
   lpht_req_type req_data;
   logic         busy;
   logic         rsp_valid;
   lpht_rsp_type rsp_data;

   bit                     slot_used [TABLE_SLOTS];
   logic [SLOT_BITS-1:0]   slot_entry [TABLE_SLOTS];
   logic [31:0]            entry_key [TABLE_SLOTS];
   logic [31:0]            entry_value [TABLE_SLOTS];
   logic [COUNT_BITS-1:0]  held_count = '0;

   lpht_rsp_type expected_rsp_q [$];
   logic [31:0]  pool_key [POOL_KEYS];
   logic [7:0]   pool_hash [POOL_KEYS];
   int           idle_pct = 0;
   int           failures = 0;
   int           requests_sent = 0;
   int           fills_done = 0;
   int           status_tally [5];

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{REQ_LOOKUP, 32'h0000_0000, 8'h00, 32'h0000_0000}, 1'b1,
        '{STATUS_MISSING, 32'h0, 9'd0}},
      '{'{REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
        '{STATUS_MISSING, 32'h0, 9'd0}},
      '{'{REQ_INSERT, 32'h0000_0000, 8'h00, 32'hFFFF_FFFF}, 1'b1,
        '{STATUS_NEW, 32'h0, 9'd1}},
      '{'{REQ_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'h0000_0000}, 1'b1,
        '{STATUS_NEW, 32'h0, 9'd2}},
      '{'{REQ_LOOKUP, 32'h0000_0000, 8'h00, 32'h0000_0000}, 1'b1,
        '{STATUS_FOUND, 32'hFFFF_FFFF, 9'd2}},
      '{'{REQ_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 32'h1234_5678}, 1'b1,
        '{STATUS_FOUND, 32'h0, 9'd2}},
      '{'{REQ_INSERT, 32'h1234_5678, 8'hFF, 32'hA5A5_A5A5}, 1'b0, '0},
      '{'{REQ_LOOKUP, 32'h1234_5678, 8'hFF, 32'h0000_0000}, 1'b0, '0},
      '{'{REQ_INSERT, 32'h0000_0000, 8'h00, 32'h5A5A_5A5A}, 1'b1,
        '{STATUS_REPLACED, 32'h0, 9'd3}},
      '{'{REQ_LOOKUP, 32'h0000_0000, 8'h00, 32'h0000_0000}, 1'b1,
        '{STATUS_FOUND, 32'h5A5A_5A5A, 9'd3}},
      '{'{REQ_LOOKUP, 32'h1234_5678, 8'h80, 32'h0000_0000}, 1'b1,
        '{STATUS_MISSING, 32'h0, 9'd3}},
      '{'{REQ_LOOKUP, 32'hDEAD_BEEF, 8'hFE, 32'h0000_0000}, 1'b0, '0},
      '{'{REQ_INSERT, 32'h8765_4321, 8'h00, 32'h0F0F_0F0F}, 1'b0, '0},
      '{'{REQ_LOOKUP, 32'h8765_4321, 8'h00, 32'h0000_0000}, 1'b0, '0},
      '{'{REQ_UNUSED, 32'h0000_0000, 8'h00, 32'h0000_0000}, 1'b1,
        '{STATUS_MISSING, 32'h0, 9'd4}},
      '{'{REQ_CLEAR, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
        '{STATUS_FOUND, 32'h0, 9'd0}},
      '{'{REQ_LOOKUP, 32'h0000_0000, 8'h00, 32'h0000_0000}, 1'b1,
        '{STATUS_MISSING, 32'h0, 9'd0}},
      '{'{REQ_INSERT, 32'hDEAD_BEEF, 8'h7F, 32'hC3C3_C3C3}, 1'b0, '0},
      '{'{REQ_CLEAR, 32'h0000_0000, 8'h00, 32'h0000_0000}, 1'b1,
        '{STATUS_FOUND, 32'h0, 9'd0}}
   };

   linear_probe_hash_table uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic probe_outcome_type probe_slots(input logic [31:0] key,
                                                     input logic [7:0] first,
                                                     output logic [7:0] where);
      logic [7:0] pos;
      pos = first;
      where = '0;
      for (int n = 0; n < TABLE_SLOTS; n++) begin
         if (!slot_used[pos]) begin
            where = pos;
            return PROBE_EMPTY;
         end
         if (entry_key[slot_entry[pos]] == key) begin
            where = slot_entry[pos];
            return PROBE_MATCH;
         end
         pos = pos + 8'd1;
      end
      return PROBE_EXHAUSTED;
   endfunction

   function automatic lpht_rsp_type predict_table_response(input lpht_req_type r);
      lpht_rsp_type      rsp;
      probe_outcome_type outcome;
      logic [7:0]        where;
      rsp.status = STATUS_MISSING;
      rsp.read_value = '0;
      case (r.req_type)
         REQ_CLEAR: begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            held_count = '0;
            rsp.status = STATUS_FOUND;
         end
         REQ_LOOKUP: begin
            if (held_count != '0) begin
               outcome = probe_slots(r.key, r.hash_value, where);
               if (outcome == PROBE_MATCH) begin
                  rsp.status = STATUS_FOUND;
                  rsp.read_value = entry_value[where];
               end else if (outcome == PROBE_EXHAUSTED) begin
                  rsp.status = STATUS_FULL;
               end
            end
         end
         REQ_INSERT: begin
            outcome = probe_slots(r.key, r.hash_value, where);
            if (outcome == PROBE_MATCH) begin
               entry_value[where] = r.value;
               rsp.status = STATUS_REPLACED;
            end else if (outcome == PROBE_EMPTY && held_count < MAX_COUNT) begin
               entry_key[held_count[SLOT_BITS-1:0]] = r.key;
               entry_value[held_count[SLOT_BITS-1:0]] = r.value;
               slot_entry[where] = held_count[SLOT_BITS-1:0];
               slot_used[where] = 1'b1;
               held_count = held_count + COUNT_BITS'(1);
               rsp.status = STATUS_NEW;
            end else begin
               rsp.status = STATUS_FULL;
            end
         end
         default: ;
      endcase
      rsp.entry_count = held_count;
      return rsp;
   endfunction

   task automatic issue_request(input lpht_req_type r, input bit fixed,
                                input lpht_rsp_type fixed_rsp);
      lpht_rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_data = r;
      start = 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = predict_table_response(r);
      expected_rsp_q.push_back(fixed ? fixed_rsp : predicted);
      requests_sent++;
   endtask

   task automatic wait_for_responses;
      @(negedge clock);
      start = 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
   endtask

   task automatic run_mixed_session(input int count);
      lpht_req_type r;
      int           pick;
      int           k;
      for (int i = 0; i < POOL_KEYS; i++) begin
         pool_key[i] = $urandom;
         pool_hash[i] = ($urandom_range(1) == 1) ? 8'hF8 + 8'($urandom_range(7))
                                                 : 8'($urandom_range(255));
      end
      pool_key[0] = 32'h0000_0000;
      pool_key[1] = 32'hFFFF_FFFF;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         k = $urandom_range(POOL_KEYS - 1);
         r.key = pool_key[k];
         r.hash_value = pool_hash[k];
         r.value = $urandom;
         if (pick < 2) begin
            r.req_type = REQ_CLEAR;
         end else if (pick < 4) begin
            r.req_type = REQ_UNUSED;
         end else if (pick < 16) begin
            r.req_type = ($urandom_range(1) == 1) ? REQ_INSERT : REQ_LOOKUP;
            r.key = $urandom;
            r.hash_value = 8'($urandom_range(255));
         end else if (pick < 55) begin
            r.req_type = REQ_INSERT;
         end else begin
            r.req_type = REQ_LOOKUP;
         end
         issue_request(r, 1'b0, '0);
      end
   endtask

   task automatic fill_to_capacity;
      lpht_req_type r;
      logic [31:0]  fill_key [TABLE_SLOTS];
      logic [7:0]   fill_hash [TABLE_SLOTS];
      int           j;
      issue_request('{REQ_CLEAR, 32'h0, 8'h00, 32'h0}, 1'b0, '0);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         fill_key[i] = {8'(i), 24'($urandom)};
         fill_hash[i] = 8'($urandom_range(255));
         issue_request('{REQ_INSERT, fill_key[i], fill_hash[i], $urandom}, 1'b0, '0);
      end
      for (int n = 0; n < 4; n++) begin
         j = $urandom_range(TABLE_SLOTS - 1);
         issue_request('{REQ_LOOKUP, fill_key[j], fill_hash[j], 32'h0}, 1'b0, '0);
      end
      j = $urandom_range(TABLE_SLOTS - 1);
      issue_request('{REQ_LOOKUP, fill_key[j] ^ 32'h1, 8'($urandom_range(255)), 32'h0},
                    1'b0, '0);
      issue_request('{REQ_INSERT, fill_key[j] ^ 32'h1, 8'($urandom_range(255)), $urandom},
                    1'b0, '0);
      issue_request('{REQ_INSERT, fill_key[j], fill_hash[j], $urandom}, 1'b0, '0);
      issue_request('{REQ_LOOKUP, fill_key[j], 8'($urandom_range(255)), 32'h0},
                    1'b0, '0);
      issue_request('{REQ_UNUSED, $urandom, 8'($urandom_range(255)), $urandom},
                    1'b0, '0);
      issue_request('{REQ_CLEAR, $urandom, 8'($urandom_range(255)), $urandom},
                    1'b0, '0);
      fills_done++;
   endtask

   always @(posedge clock) begin : response_check
      lpht_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response: status %0d, read_value %h, entry_count %0d",
                   rsp_data.status, rsp_data.read_value, rsp_data.entry_count);
            failures++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value: expected %h, actual %h",
                      want.read_value, rsp_data.read_value);
               failures++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      want.entry_count, rsp_data.entry_count);
               failures++;
            end
         end
         if (rsp_data.status <= STATUS_FULL) status_tally[rsp_data.status]++;
      end
   end

   initial begin
      #60_000_000;
      $display("linear_probe_hash_table test failed");
      $finish;
   end

   initial begin
      int pacing [3];
      pacing = '{0, 80, 6};
      foreach (status_tally[i]) status_tally[i] = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         issue_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
      wait_for_responses();

      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = pacing[ph];
         run_mixed_session(MIXED_REQUESTS);
         wait_for_responses();
         fill_to_capacity();
         wait_for_responses();
      end

      repeat (16) @(posedge clock);
      $display("Covered %0d requests under three pacing phases, with %0d fills to capacity.",
               requests_sent, fills_done);
      $display("Responses seen: found %0d, missing %0d, new %0d, replaced %0d, full %0d.",
               status_tally[STATUS_FOUND], status_tally[STATUS_MISSING],
               status_tally[STATUS_NEW], status_tally[STATUS_REPLACED],
               status_tally[STATUS_FULL]);
      if (failures == 0 && expected_rsp_q.size() == 0) begin
         $display("linear_probe_hash_table test passed");
      end else begin
         $display("linear_probe_hash_table test failed");
      end
      $finish;
   end

endmodule
